// File: rtl/core/bfb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and fixed-point helpers for the ball flight and bounce stepper.
package bfb_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int BOUNCE_BITS_DEF = 8;
	localparam int DT_BITS         = 16;
	localparam int REST_BITS       = 16;
	localparam int AXIS_FRAC       = 8;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic [2:0] CFG_DRAG    = 3'd0;
	localparam logic [2:0] CFG_LIFT    = 3'd1;
	localparam logic [2:0] CFG_WAKE    = 3'd2;
	localparam logic [2:0] CFG_GRAVITY = 3'd3;
	localparam logic [2:0] CFG_RADIUS  = 3'd4;
	localparam logic [2:0] CFG_REST    = 3'd5;
	localparam logic [2:0] CFG_FRICT   = 3'd6;
	localparam logic [2:0] CFG_AXIS    = 3'd7;

	localparam logic [30:0] GRAVITY_RST = 31'd642252;
	localparam logic [30:0] RADIUS_RST  = 31'd2425;
	localparam logic [16:0] REST_RST    = 17'd32768;

	typedef struct packed {
		logic               command;
		logic [15:0]        time_step;
		logic signed [31:0] start_pos_x;
		logic signed [31:0] start_pos_y;
		logic signed [31:0] start_pos_z;
		logic signed [31:0] start_vel_x;
		logic signed [31:0] start_vel_y;
		logic signed [31:0] start_vel_z;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [7:0]         bounce_count;
		logic               stopped;
		logic               flight_held;
		logic               saturated;
	} res_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} clip_t;

	function automatic clip_t clip32(input logic [67:0] x);
		clip_t r;
		r.ovf = !((&x[67:31]) || (~|x[67:31]));
		if (r.ovf) begin
			r.val = x[67] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			r.val = x[31:0];
		end
		return r;
	endfunction

	function automatic logic [67:0] s68(input logic [31:0] x);
		return {{36{x[31]}}, x};
	endfunction

	function automatic logic [67:0] p68(input logic [65:0] x);
		return {{2{x[65]}}, x};
	endfunction

	function automatic logic signed [32:0] s33(input logic [31:0] x);
		return {x[31], x};
	endfunction

	function automatic logic signed [32:0] a33(input logic [15:0] x);
		return {{17{x[15]}}, x};
	endfunction

endpackage

// File: rtl/core/bfb_sqrt.sv
`timescale 1ns / 1ps
// Bit-serial integer square root of a 64-bit radicand, one result bit per cycle.
module bfb_sqrt import bfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [6:0]  sh;
	logic [63:0] bit_v;
	logic [63:0] trial;

	assign sh    = 7'd62 - {1'b0, step_q, 1'b0};
	assign bit_v = 64'd1 << sh;
	assign trial = r_q + bit_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			r_q    <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q    <= radicand;
				r_q    <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (n_q >= trial) begin
					n_q <= n_q - trial;
					r_q <= (r_q >> 1) + bit_v;
				end else begin
					r_q <= r_q >> 1;
				end
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = r_q[31:0];

endmodule

// File: rtl/core/bfb_div.sv
`timescale 1ns / 1ps
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module bfb_div import bfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quot
);

	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] dvs_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] t;
	logic        ge;

	assign t  = {rem_q, lo_q[31]};
	assign ge = t >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			lo_q   <= '0;
			dvs_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= dividend[63:32];
				lo_q   <= dividend[31:0];
				dvs_q  <= divisor;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? 32'(t - {1'b0, dvs_q}) : t[31:0];
				lo_q   <= {lo_q[30:0], ge};
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = lo_q;

endmodule

// File: rtl/core/ball_flight_bounce_step.sv
`timescale 1ns / 1ps
// Top level of the ball flight and bounce stepper.
//
// Usage: configuration registers are written through cfg_write/cfg_index/cfg_data while
// the block is idle. Command beats arrive on cmd (cmd_valid/cmd_stall); each yields one
// result beat on res (res_valid/res_stall). A start beat loads position and velocity and
// clears the contact counter and slip; a tick beat advances the ball by time_step.
// Run time: a start beat goes straight to the result stage. A flight tick skips the lift
// normalization and its divisions when the lift direction is zero, a slow flight tick
// ends after the speed square root, and a bounce tick without ground contact skips the
// bounce and friction steps. The run time comes from the sequencer sharing one 33x33
// multiplier, a bit-serial square root and a bit-serial divider; the normalization of
// the lift direction shifts one bit per cycle.
// Throughput: one beat at a time; cmd_stall is high from acceptance until the result is
// placed in the output register.
// A result waiting under res_stall is held while the next command is accepted and worked;
// a second result waits until the first is taken.
// Reset clears the ball state, the counter and the result valid, and loads the
// register defaults.
module ball_flight_bounce_step import bfb_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int BOUNCE_BITS = BOUNCE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int THR_SPEED = ((1 << FRAC_BITS) + 5) / 10;
	localparam int THR_REST  = ((1 << FRAC_BITS) + 500) / 1000;
	localparam int THR_SLIP  = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam logic [BOUNCE_BITS-1:0] CNT_MAX = '1;

	localparam logic [5:0] ST_IDLE = 6'd0;
	localparam logic [5:0] ST_SS   = 6'd1;
	localparam logic [5:0] ST_RT   = 6'd2;
	localparam logic [5:0] ST_RTW  = 6'd3;
	localparam logic [5:0] ST_K0   = 6'd4;
	localparam logic [5:0] ST_K1   = 6'd5;
	localparam logic [5:0] ST_K2   = 6'd6;
	localparam logic [5:0] ST_K3   = 6'd7;
	localparam logic [5:0] ST_K4   = 6'd8;
	localparam logic [5:0] ST_K5   = 6'd9;
	localparam logic [5:0] ST_K6   = 6'd10;
	localparam logic [5:0] ST_K7   = 6'd11;
	localparam logic [5:0] ST_X    = 6'd12;
	localparam logic [5:0] ST_N0   = 6'd13;
	localparam logic [5:0] ST_NS   = 6'd14;
	localparam logic [5:0] ST_DV   = 6'd15;
	localparam logic [5:0] ST_DW   = 6'd16;
	localparam logic [5:0] ST_A0   = 6'd17;
	localparam logic [5:0] ST_A1   = 6'd18;
	localparam logic [5:0] ST_A2   = 6'd19;
	localparam logic [5:0] ST_A3   = 6'd20;
	localparam logic [5:0] ST_A4   = 6'd21;
	localparam logic [5:0] ST_P0   = 6'd22;
	localparam logic [5:0] ST_P1   = 6'd23;
	localparam logic [5:0] ST_G0   = 6'd24;
	localparam logic [5:0] ST_G1   = 6'd25;
	localparam logic [5:0] ST_B0   = 6'd26;
	localparam logic [5:0] ST_B1   = 6'd27;
	localparam logic [5:0] ST_B2   = 6'd28;
	localparam logic [5:0] ST_B3   = 6'd29;
	localparam logic [5:0] ST_F0   = 6'd30;
	localparam logic [5:0] ST_F1   = 6'd31;
	localparam logic [5:0] ST_M    = 6'd32;
	localparam logic [5:0] ST_DONE = 6'd33;

	localparam logic [1:0] SEL_VEL  = 2'd0;
	localparam logic [1:0] SEL_NRM  = 2'd1;
	localparam logic [1:0] SEL_SLIP = 2'd2;

	logic [5:0]  state_q;
	logic [2:0]  idx_q;
	logic [1:0]  sel_q;
	logic [15:0] dt_q;

	logic [30:0]        drag_q, lift_q, grav_q, rad_q, fric_q;
	logic [31:0]        wake_q;
	logic [16:0]        rest_q;
	logic signed [15:0] ax_q [3];

	logic signed [31:0] pos_q  [3];
	logic signed [31:0] vel_q  [3];
	logic signed [31:0] slip_q [2];
	logic signed [31:0] u_q    [3];
	logic signed [49:0] c_q    [3];
	logic [47:0]        m_q    [3];
	logic [BOUNCE_BITS-1:0] cnt_q;

	logic [63:0]        acc_q;
	logic signed [49:0] cacc_q;
	logic signed [31:0] spd_q, kd_q, mag_q, aw_q, tmp_q, f_q;
	logic [31:0]        len_q, slen_q;
	logic               held_q, sat_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	logic signed [65:0] q_sh, d_sh, a_sh;
	clip_t              qc, dc, sc;
	logic [67:0]        sum_x;

	logic        sq_start, sq_busy, sq_done;
	logic [31:0] sq_root;
	logic        dv_start, dv_busy, dv_done;
	logic [31:0] dv_quot;
	logic [63:0] dv_num;

	logic [47:0] mx;
	logic        sh_r, sh_l;
	logic [1:0]  cidx, vidx;
	logic signed [32:0] dy;
	logic [32:0] dy_mag, vy_mag;
	logic        stop_w;
	logic        res_valid_q;
	res_t        res_q;
	logic        pos1_low;

	assign q_sh = prod_q >>> FRAC_BITS;
	assign d_sh = prod_q >>> DT_BITS;
	assign a_sh = prod_q >>> AXIS_FRAC;
	assign qc   = clip32(p68(q_sh));
	assign dc   = clip32(p68(d_sh));
	assign cidx = 2'(idx_q[2:1] - 2'd1);
	assign vidx = idx_q[0] ? 2'd2 : 2'd0;
	assign pos1_low = pos_q[1] <= $signed({1'b0, rad_q});

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_SS: begin
				if (idx_q < 3'd3) begin
					case (sel_q)
						SEL_VEL: ma = s33(vel_q[idx_q[1:0]]);
						SEL_NRM: ma = {3'b0, m_q[idx_q[1:0]][29:0]};
						default: begin
							if (idx_q < 3'd2) ma = s33(slip_q[idx_q[0]]);
						end
					endcase
				end
				mb = ma;
			end
			ST_K0: begin ma = {2'b0, drag_q}; mb = s33(spd_q); end
			ST_K1: begin ma = {2'b0, lift_q}; mb = s33(spd_q); end
			ST_K3: begin ma = s33(tmp_q); mb = s33(spd_q); end
			ST_K4: begin ma = s33(wake_q); mb = s33(spd_q); end
			ST_K6: begin ma = s33(tmp_q); mb = s33(spd_q); end
			ST_X: begin
				case (idx_q)
					3'd0: begin ma = a33(ax_q[1]); mb = s33(vel_q[2]); end
					3'd1: begin ma = a33(ax_q[2]); mb = s33(vel_q[1]); end
					3'd2: begin ma = a33(ax_q[2]); mb = s33(vel_q[0]); end
					3'd3: begin ma = a33(ax_q[0]); mb = s33(vel_q[2]); end
					3'd4: begin ma = a33(ax_q[0]); mb = s33(vel_q[1]); end
					3'd5: begin ma = a33(ax_q[1]); mb = s33(vel_q[0]); end
					default: ;
				endcase
			end
			ST_A0: begin ma = s33(kd_q); mb = s33(vel_q[idx_q[1:0]]); end
			ST_A1: begin ma = s33(mag_q); mb = s33(u_q[idx_q[1:0]]); end
			ST_A3: begin ma = s33(tmp_q); mb = {17'b0, dt_q}; end
			ST_P0: begin ma = s33(vel_q[idx_q[1:0]]); mb = {17'b0, dt_q}; end
			ST_G0: begin ma = {2'b0, grav_q}; mb = {17'b0, dt_q}; end
			ST_B0: begin ma = -s33(vel_q[1]); mb = {16'b0, rest_q}; end
			ST_B1: begin ma = a33(ax_q[2]); mb = {2'b0, rad_q}; end
			ST_B2: begin ma = a33(ax_q[0]); mb = {2'b0, rad_q}; end
			ST_F0: begin ma = {2'b0, fric_q}; mb = {17'b0, dt_q}; end
			ST_M: begin
				ma = slip_q[idx_q[0]][31] ? -s33(slip_q[idx_q[0]]) : s33(slip_q[idx_q[0]]);
				mb = s33(f_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		sum_x = '0;
		case (state_q)
			ST_A2: sum_x = s68(qc.val) - s68(tmp_q)
				+ ((idx_q == 3'd0) ? s68(aw_q) : 68'd0)
				- ((idx_q == 3'd1) ? {37'b0, grav_q} : 68'd0);
			ST_A4: sum_x = s68(vel_q[idx_q[1:0]]) + s68(dc.val);
			ST_P1: sum_x = s68(pos_q[idx_q[1:0]]) + s68(dc.val);
			ST_G1: sum_x = s68(vel_q[1]) - s68(dc.val);
			ST_B1: sum_x = p68(prod_q >>> REST_BITS);
			ST_B2: sum_x = s68(vel_q[0]) + p68(a_sh);
			ST_B3: sum_x = s68(vel_q[2]) - p68(a_sh);
			ST_DW: sum_x = s68(vel_q[vidx]) - (slip_q[idx_q[0]][31] ?
				-{36'b0, dv_quot} : {36'b0, dv_quot});
			default: ;
		endcase
	end
	assign sc = clip32(sum_x);

	always_comb begin
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
	end
	assign sh_r = |mx[47:30];
	assign sh_l = !mx[29] && !sh_r;

	assign sq_start = state_q == ST_RT;
	assign dv_start = state_q == ST_DV;
	assign dv_num   = (sel_q == SEL_NRM) ? (64'(m_q[idx_q[1:0]][29:0]) << FRAC_BITS)
		: 64'(prod_q[63:0]);

	bfb_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_q),
		.busy     (sq_busy),
		.done     (sq_done),
		.root     (sq_root)
	);

	bfb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_num),
		.divisor  (len_q),
		.busy     (dv_busy),
		.done     (dv_done),
		.quot     (dv_quot)
	);

	always_ff @(posedge clk) begin
		prod_q <= 66'(ma) * 66'(mb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			sel_q   <= SEL_VEL;
			dt_q    <= '0;
			drag_q  <= '0;
			lift_q  <= '0;
			wake_q  <= '0;
			grav_q  <= GRAVITY_RST;
			rad_q   <= RADIUS_RST;
			rest_q  <= REST_RST;
			fric_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				ax_q[i]  <= '0;
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				u_q[i]   <= '0;
				c_q[i]   <= '0;
				m_q[i]   <= '0;
			end
			slip_q[0] <= '0;
			slip_q[1] <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			cacc_q  <= '0;
			spd_q   <= '0;
			kd_q    <= '0;
			mag_q   <= '0;
			aw_q    <= '0;
			tmp_q   <= '0;
			f_q     <= '0;
			len_q   <= '0;
			slen_q  <= '0;
			held_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_DRAG:    drag_q <= cfg_data[30:0];
					CFG_LIFT:    lift_q <= cfg_data[30:0];
					CFG_WAKE:    wake_q <= cfg_data[31:0];
					CFG_GRAVITY: grav_q <= cfg_data[30:0];
					CFG_RADIUS:  rad_q  <= cfg_data[30:0];
					CFG_REST:    rest_q <= cfg_data[16:0];
					CFG_FRICT:   fric_q <= cfg_data[30:0];
					CFG_AXIS: begin
						ax_q[0] <= cfg_data[15:0];
						ax_q[1] <= cfg_data[31:16];
						ax_q[2] <= cfg_data[47:32];
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						held_q <= 1'b0;
						sat_q  <= 1'b0;
						dt_q   <= cmd.time_step;
						idx_q  <= '0;
						sel_q  <= SEL_VEL;
						if (cmd.command == CMD_START) begin
							pos_q[0]  <= cmd.start_pos_x;
							pos_q[1]  <= cmd.start_pos_y;
							pos_q[2]  <= cmd.start_pos_z;
							vel_q[0]  <= cmd.start_vel_x;
							vel_q[1]  <= cmd.start_vel_y;
							vel_q[2]  <= cmd.start_vel_z;
							slip_q[0] <= '0;
							slip_q[1] <= '0;
							slen_q    <= '0;
							cnt_q     <= '0;
							state_q   <= ST_DONE;
						end else if (cnt_q == '0) begin
							state_q <= ST_SS;
						end else begin
							state_q <= ST_G0;
						end
					end
				end
				ST_SS: begin
					acc_q <= (idx_q == 3'd0) ? 64'd0 : acc_q + prod_q[63:0];
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd3) state_q <= ST_RT;
				end
				ST_RT: state_q <= ST_RTW;
				ST_RTW: begin
					if (sq_done) begin
						idx_q <= '0;
						case (sel_q)
							SEL_VEL: begin
								if (sq_root < 32'(THR_SPEED)) begin
									held_q  <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									spd_q   <= sq_root[31] ? 32'h7FFF_FFFF : sq_root;
									sat_q   <= sat_q | sq_root[31];
									state_q <= ST_K0;
								end
							end
							SEL_NRM: begin
								len_q   <= sq_root;
								state_q <= ST_DV;
							end
							default: begin
								len_q  <= sq_root;
								slen_q <= sq_root;
								state_q <= (sq_root > 32'(THR_SLIP)) ? ST_F0 : ST_DONE;
							end
						endcase
					end
				end
				ST_K0: state_q <= ST_K1;
				ST_K1: begin
					kd_q <= qc.val; sat_q <= sat_q | qc.ovf; state_q <= ST_K2;
				end
				ST_K2: begin
					tmp_q <= qc.val; sat_q <= sat_q | qc.ovf; state_q <= ST_K3;
				end
				ST_K3: state_q <= ST_K4;
				ST_K4: begin
					mag_q <= qc.val; sat_q <= sat_q | qc.ovf; state_q <= ST_K5;
				end
				ST_K5: begin
					tmp_q <= qc.val; sat_q <= sat_q | qc.ovf; state_q <= ST_K6;
				end
				ST_K6: state_q <= ST_K7;
				ST_K7: begin
					aw_q    <= qc.val;
					sat_q   <= sat_q | qc.ovf;
					idx_q   <= '0;
					state_q <= ST_X;
				end
				ST_X: begin
					if (idx_q != 3'd0) begin
						if (idx_q[0]) cacc_q <= prod_q[49:0];
						else c_q[cidx] <= cacc_q - prod_q[49:0];
					end
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd6) state_q <= ST_N0;
				end
				ST_N0: begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= 48'(c_q[i][49] ? -c_q[i] : c_q[i]);
					end
					idx_q <= '0;
					if (c_q[0] == '0 && c_q[1] == '0 && c_q[2] == '0) begin
						for (int i = 0; i < 3; i++) u_q[i] <= '0;
						state_q <= ST_A0;
					end else begin
						state_q <= ST_NS;
					end
				end
				ST_NS: begin
					if (sh_r) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else if (sh_l) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						sel_q   <= SEL_NRM;
						idx_q   <= '0;
						state_q <= ST_SS;
					end
				end
				ST_DV: state_q <= ST_DW;
				ST_DW: begin
					if (dv_done) begin
						if (sel_q == SEL_NRM) begin
							u_q[idx_q[1:0]] <= c_q[idx_q[1:0]][49] ? -dv_quot : dv_quot;
							if (idx_q == 3'd2) begin
								idx_q   <= '0;
								state_q <= ST_A0;
							end else begin
								idx_q   <= idx_q + 3'd1;
								state_q <= ST_DV;
							end
						end else begin
							vel_q[vidx] <= sc.val;
							sat_q       <= sat_q | sc.ovf;
							if (idx_q[0]) begin
								if (cnt_q < CNT_MAX) cnt_q <= cnt_q + 1'b1;
								state_q <= ST_DONE;
							end else begin
								idx_q   <= 3'd1;
								state_q <= ST_M;
							end
						end
					end
				end
				ST_A0: state_q <= ST_A1;
				ST_A1: begin
					tmp_q <= qc.val; sat_q <= sat_q | qc.ovf; state_q <= ST_A2;
				end
				ST_A2: begin
					tmp_q   <= sc.val;
					sat_q   <= sat_q | qc.ovf | sc.ovf;
					state_q <= ST_A3;
				end
				ST_A3: state_q <= ST_A4;
				ST_A4: begin
					vel_q[idx_q[1:0]] <= sc.val;
					sat_q <= sat_q | dc.ovf | sc.ovf;
					if (idx_q == 3'd2) begin
						idx_q   <= '0;
						state_q <= ST_P0;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= ST_A0;
					end
				end
				ST_P0: state_q <= ST_P1;
				ST_P1: begin
					pos_q[idx_q[1:0]] <= sc.val;
					sat_q <= sat_q | dc.ovf | sc.ovf;
					if (idx_q == 3'd2) begin
						idx_q <= '0;
						if (cnt_q == '0) begin
							if (pos1_low && cnt_q < CNT_MAX) cnt_q <= cnt_q + 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= pos1_low ? ST_B0 : ST_DONE;
						end
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= ST_P0;
					end
				end
				ST_G0: state_q <= ST_G1;
				ST_G1: begin
					vel_q[1] <= sc.val;
					sat_q    <= sat_q | dc.ovf | sc.ovf;
					idx_q    <= '0;
					state_q  <= ST_P0;
				end
				ST_B0: begin
					pos_q[1] <= {1'b0, rad_q};
					state_q  <= ST_B1;
				end
				ST_B1: begin
					vel_q[1] <= sc.val; sat_q <= sat_q | sc.ovf; state_q <= ST_B2;
				end
				ST_B2: begin
					slip_q[0] <= sc.val; sat_q <= sat_q | sc.ovf; state_q <= ST_B3;
				end
				ST_B3: begin
					slip_q[1] <= sc.val;
					sat_q     <= sat_q | sc.ovf;
					sel_q     <= SEL_SLIP;
					idx_q     <= '0;
					state_q   <= ST_SS;
				end
				ST_F0: state_q <= ST_F1;
				ST_F1: begin
					f_q     <= dc.val;
					sat_q   <= sat_q | dc.ovf;
					idx_q   <= '0;
					state_q <= ST_M;
				end
				ST_M: state_q <= ST_DV;
				ST_DONE: begin
					if (!res_valid_q || !res_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign dy     = 33'(pos_q[1]) - $signed({2'b0, rad_q});
	assign dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
	assign vy_mag = vel_q[1][31] ? -s33(vel_q[1]) : s33(vel_q[1]);
	assign stop_w = (dy_mag < 33'(THR_REST)) && (vy_mag < 33'(THR_SPEED))
		&& (slen_q < 32'(THR_SPEED));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!res_valid_q || !res_stall)) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!res_valid_q || !res_stall)) begin
			res_q.pos_x        <= pos_q[0];
			res_q.pos_y        <= pos_q[1];
			res_q.pos_z        <= pos_q[2];
			res_q.vel_x        <= vel_q[0];
			res_q.vel_y        <= vel_q[1];
			res_q.vel_z        <= vel_q[2];
			res_q.bounce_count <= 8'(cnt_q);
			res_q.stopped      <= stop_w;
			res_q.flight_held  <= held_q;
			res_q.saturated    <= sat_q;
		end
	end

	assign cmd_stall = state_q != ST_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		sq_busy |-> !dv_busy)
		else $error("sqrt and divider busy together");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1) || (cnt_q == '0))
		else $error("contact counter jumped");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");

endmodule
